// ===== hw/rtl/evs_pkg.sv =====
package evs_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned MaxChunkDefault  = 4096;
  localparam int unsigned CountBitsDefault = 48;

  // Fixed field widths.
  localparam int unsigned SampleWidth  = 16;
  localparam int unsigned IndexWidth   = 48;
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 31;
  localparam int unsigned ThrWidth     = 31;
  localparam int unsigned PrerollWidth = 16;
  localparam int unsigned DurWidth     = 24;
  localparam int unsigned SegWidth     = 25;
  // Width of one squared sample: the largest square is exactly 2^30.
  localparam int unsigned SqWidth      = 31;

  // Register reset values.
  localparam logic                    ModeReset      = 1'b0;
  localparam logic [ThrWidth-1:0]     ThrReset       = 31'd1048576;
  localparam logic [PrerollWidth-1:0] PrerollReset   = 16'd4800;
  localparam logic [DurWidth-1:0]     HoldReset      = 24'd16000;
  localparam logic [DurWidth-1:0]     MaxSegReset    = 24'd480000;
  localparam logic [DurWidth-1:0]     OverlapReset   = 24'd0;
  localparam logic [DurWidth-1:0]     RingReset      = 24'd480000;

  // Configuration register indexes.
  typedef enum logic [CfgIdxWidth-1:0] {
    CfgMode    = 3'd0,
    CfgThrSq   = 3'd1,
    CfgPreroll = 3'd2,
    CfgHold    = 3'd3,
    CfgMaxSeg  = 3'd4,
    CfgOverlap = 3'd5,
    CfgRing    = 3'd6
  } cfg_idx_e;

  // Input operation codes.
  typedef enum logic {
    OpSample = 1'b0,
    OpFlush  = 1'b1
  } op_e;

  // Segmentation modes.
  typedef enum logic {
    ModeEnergy = 1'b0,
    ModeFixed  = 1'b1
  } mode_e;

endpackage

// ===== hw/rtl/energy_vad_segmenter.sv =====
// Energy-based voice activity segmenter. Samples (op sample) are squared and
// summed per chunk; a chunk closes on last_in_chunk or after MaxChunk samples,
// and its energy is tested against threshold_sq times the chunk length. Each
// chunk end and each flush yields one result transfer, other samples yield
// none. The block accepts one item per clock cycle when the output is taken.
// Each input passes through an input register, a stage holding the squaring
// and threshold multipliers with the chunk accumulators, and a decision
// stage that updates the speech state and fills the output register.
// No clearing pass is needed after reset.
// Configuration writes are always accepted and take effect at once; they are
// meant to be made while the block is idle.
module energy_vad_segmenter #(
  parameter int unsigned MaxChunk  = evs_pkg::MaxChunkDefault,
  parameter int unsigned CountBits = evs_pkg::CountBitsDefault
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Configuration write channel.
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [evs_pkg::CfgIdxWidth-1:0]       cfg_index_i,
  input  logic [evs_pkg::CfgDataWidth-1:0]      cfg_data_i,
  // Input channel.
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  op_i,
  input  logic signed [evs_pkg::SampleWidth-1:0] sample_i,
  input  logic                                  last_in_chunk_i,
  // Result channel.
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  speech_active_o,
  output logic                                  vad_onset_o,
  output logic                                  vad_offset_o,
  output logic                                  segment_valid_o,
  output logic [evs_pkg::IndexWidth-1:0]        segment_start_o,
  output logic [evs_pkg::IndexWidth-1:0]        segment_end_o
);
  import evs_pkg::*;

  localparam int unsigned LenWidth = $clog2(MaxChunk + 1);
  localparam int unsigned EngWidth = LenWidth + SqWidth - 1;
  localparam int unsigned RefWidth = LenWidth + ThrWidth;
  localparam int unsigned CW       = CountBits;

  // ---------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------
  logic                    mode_q;
  logic [ThrWidth-1:0]     thr_q;
  logic [PrerollWidth-1:0] preroll_q;
  logic [DurWidth-1:0]     hold_q, max_seg_q, overlap_q, ring_q;

  assign cfg_ready_o = 1'b1;

  // Each write lands in the register it names; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= ModeReset;
      thr_q     <= ThrReset;
      preroll_q <= PrerollReset;
      hold_q    <= HoldReset;
      max_seg_q <= MaxSegReset;
      overlap_q <= OverlapReset;
      ring_q    <= RingReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgMode:    mode_q    <= cfg_data_i[0];
        CfgThrSq:   thr_q     <= cfg_data_i[ThrWidth-1:0];
        CfgPreroll: preroll_q <= cfg_data_i[PrerollWidth-1:0];
        CfgHold:    hold_q    <= cfg_data_i[DurWidth-1:0];
        CfgMaxSeg:  max_seg_q <= cfg_data_i[DurWidth-1:0];
        CfgOverlap: overlap_q <= cfg_data_i[DurWidth-1:0];
        CfgRing:    ring_q    <= cfg_data_i[DurWidth-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Handshake chain: each stage advances when the one after it has room.
  // ---------------------------------------------------------------------
  logic in_valid_q, mid_valid_q, out_valid_q;
  logic out_room, fire_b, mid_room, fire_a, in_accept;

  assign out_room   = !out_valid_q || out_ready_i;
  assign fire_b     = mid_valid_q && out_room;
  assign mid_room   = !mid_valid_q || out_room;
  assign fire_a     = in_valid_q && mid_room;
  assign in_ready_o = !in_valid_q || mid_room;
  assign in_accept  = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------
  // Input register.
  // ---------------------------------------------------------------------
  logic                          in_op_q, in_last_q;
  logic signed [SampleWidth-1:0] in_sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (fire_a) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_op_q     <= op_i;
      in_sample_q <= sample_i;
      in_last_q   <= last_in_chunk_i;
    end
  end

  // ---------------------------------------------------------------------
  // Stage A: square, accumulate the chunk, count samples, form the
  // threshold reference for the chunk so far.
  // ---------------------------------------------------------------------
  logic [CW-1:0]         tw_q, tw_d;
  logic [EngWidth-1:0]   eng_q, eng_d, eng_sum;
  logic [LenWidth-1:0]   len_q, len_d, len_inc;
  logic signed [31:0]    sq_full;
  logic [RefWidth-1:0]   ref_a;
  logic                  a_flush, a_end;

  assign sq_full = in_sample_q * in_sample_q;
  assign eng_sum = eng_q + EngWidth'(sq_full[SqWidth-1:0]);
  assign len_inc = len_q + LenWidth'(1);
  assign ref_a   = RefWidth'(thr_q) * RefWidth'(len_inc);
  assign a_flush = (in_op_q == OpFlush);
  assign a_end   = in_last_q || (len_inc == LenWidth'(MaxChunk));

  always_comb begin
    tw_d  = tw_q;
    eng_d = eng_q;
    len_d = len_q;
    if (a_flush) begin
      eng_d = '0;
      len_d = '0;
    end else begin
      tw_d = (&tw_q) ? tw_q : tw_q + CW'(1);
      if (a_end) begin
        eng_d = '0;
        len_d = '0;
      end else begin
        eng_d = eng_sum;
        len_d = len_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tw_q  <= '0;
      eng_q <= '0;
      len_q <= '0;
    end else if (fire_a) begin
      tw_q  <= tw_d;
      eng_q <= eng_d;
      len_q <= len_d;
    end
  end

  // Stage A to stage B register.
  logic                mid_flush_q, mid_end_q;
  logic [EngWidth-1:0] mid_eng_q;
  logic [LenWidth-1:0] mid_len_q;
  logic [RefWidth-1:0] mid_ref_q;
  logic [CW-1:0]       mid_tw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
    end else if (fire_a) begin
      mid_valid_q <= 1'b1;
    end else if (fire_b) begin
      mid_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_a) begin
      mid_flush_q <= a_flush;
      mid_end_q   <= a_end;
      mid_eng_q   <= eng_sum;
      mid_len_q   <= len_inc;
      mid_ref_q   <= ref_a;
      mid_tw_q    <= tw_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage B: speech state and segment decisions at a chunk end or flush.
  // ---------------------------------------------------------------------
  logic [CW-1:0]       ss_q, ss_d;
  logic                sp_q, sp_d;
  logic [DurWidth-1:0] sil_q, sil_d;
  logic [SegWidth-1:0] seg_q, seg_d;

  logic [RefWidth-1:0] eng_ext;
  logic                loud_gt, quiet_lt;
  logic [SegWidth:0]   seg_sum;
  logic [SegWidth-1:0] seg_new;
  logic [DurWidth:0]   sil_sum;
  logic [DurWidth-1:0] sil_new;
  logic [CW-1:0]       back_pre, back_ring, back_ovl, onset_start;
  logic                tw_after;
  logic                has_result;
  logic                r_onset, r_offset, r_valid;
  logic [CW-1:0]       r_s0, r_s1;

  assign eng_ext  = RefWidth'(mid_eng_q);
  assign loud_gt  = eng_ext > mid_ref_q;
  assign quiet_lt = eng_ext < mid_ref_q;
  assign tw_after = mid_tw_q > ss_q;

  // Saturating length counters.
  assign seg_sum = {1'b0, seg_q} + (SegWidth + 1)'(mid_len_q);
  assign seg_new = seg_sum[SegWidth] ? '1 : seg_sum[SegWidth-1:0];
  assign sil_sum = {1'b0, sil_q} + (DurWidth + 1)'(mid_len_q);
  assign sil_new = sil_sum[DurWidth] ? '1 : sil_sum[DurWidth-1:0];

  // Back-dated start candidates, floored at zero.
  always_comb begin
    logic [CW-1:0] pre_len;
    pre_len     = CW'(mid_len_q) + CW'(preroll_q);
    back_pre    = (mid_tw_q > pre_len) ? mid_tw_q - pre_len : '0;
    back_ring   = (mid_tw_q > CW'(ring_q)) ? mid_tw_q - CW'(ring_q) : '0;
    back_ovl    = (mid_tw_q > CW'(overlap_q)) ? mid_tw_q - CW'(overlap_q) : '0;
    onset_start = (back_pre > back_ring) ? back_pre : back_ring;
  end

  always_comb begin
    ss_d       = ss_q;
    sp_d       = sp_q;
    sil_d      = sil_q;
    seg_d      = seg_q;
    has_result = mid_flush_q || mid_end_q;
    r_onset    = 1'b0;
    r_offset   = 1'b0;
    r_valid    = 1'b0;
    r_s0       = ss_q;
    r_s1       = mid_tw_q;
    if (mid_flush_q) begin
      // Flush closes whatever is pending.
      r_offset = 1'b1;
      r_valid  = tw_after;
      ss_d     = mid_tw_q;
      sp_d     = 1'b0;
      sil_d    = '0;
      seg_d    = '0;
    end else if (mid_end_q) begin
      if (mode_q == ModeEnergy) begin
        if (!sp_q) begin
          if (loud_gt) begin
            sp_d    = 1'b1;
            r_onset = 1'b1;
            ss_d    = onset_start;
            sil_d   = '0;
            seg_d   = SegWidth'(mid_len_q);
          end
        end else begin
          seg_d = seg_new;
          if (quiet_lt) begin
            sil_d = sil_new;
            if (sil_new >= hold_q) begin
              sp_d     = 1'b0;
              r_offset = 1'b1;
              r_valid  = tw_after;
              ss_d     = mid_tw_q;
              sil_d    = '0;
              seg_d    = '0;
            end
          end else begin
            sil_d = '0;
            // Over-long segment is cut and speech carries on.
            if (seg_new >= SegWidth'(max_seg_q)) begin
              r_valid = tw_after;
              ss_d    = mid_tw_q;
              seg_d   = '0;
            end
          end
        end
      end else begin
        seg_d = seg_new;
        if (seg_new >= SegWidth'(max_seg_q)) begin
          r_valid = tw_after;
          ss_d    = back_ovl;
          seg_d   = SegWidth'(overlap_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ss_q  <= '0;
      sp_q  <= 1'b0;
      sil_q <= '0;
      seg_q <= '0;
    end else if (fire_b) begin
      ss_q  <= ss_d;
      sp_q  <= sp_d;
      sil_q <= sil_d;
      seg_q <= seg_d;
    end
  end

  // ---------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------
  logic [CW+IndexWidth-1:0] s0_ext, s1_ext;

  assign s0_ext = {{IndexWidth{1'b0}}, (r_valid ? r_s0 : CW'(0))};
  assign s1_ext = {{IndexWidth{1'b0}}, (r_valid ? r_s1 : CW'(0))};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire_b && has_result) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_b && has_result) begin
      speech_active_o <= sp_d;
      vad_onset_o     <= r_onset;
      vad_offset_o    <= r_offset;
      segment_valid_o <= r_valid;
      segment_start_o <= s0_ext[IndexWidth-1:0];
      segment_end_o   <= s1_ext[IndexWidth-1:0];
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== bench/testbench.sv =====
module testbench;
  import evs_pkg::*;

  localparam int unsigned MaxChunk = MaxChunkDefault;
  localparam int Phases     = 16;
  localparam int PhaseItems = 95;
  // Cycles allowed for items still in the pipeline that give no result.
  localparam int Settle     = 6;
  localparam int HoldOff    = 400;
  localparam int Watchdog   = 3000;

  localparam logic [IndexWidth-1:0] CountMax = '1;
  localparam longint unsigned DurMax = 64'hFF_FFFF;
  localparam longint unsigned SegMax = 64'h1FF_FFFF;
  localparam logic [CfgIdxWidth-1:0] CfgUnused = 3'd7;

  // Amplitude classes for generated chunks.
  localparam int ClsQuiet = 0;
  localparam int ClsLoud  = 1;
  localparam int ClsEqual = 2;
  localparam int ClsNoise = 3;

  typedef struct packed {
    logic                  active;
    logic                  onset;
    logic                  offset;
    logic                  seg_valid;
    logic [IndexWidth-1:0] seg_start;
    logic [IndexWidth-1:0] seg_end;
  } vad_event_t;

  // Tracks the segmenter state and holds the chunk and flush events still due.
  class segment_tracker;
    mode_e                   mode;
    logic [ThrWidth-1:0]     thr_sq;
    logic [PrerollWidth-1:0] preroll;
    logic [DurWidth-1:0]     hold, max_seg, overlap, ring;

    logic [IndexWidth-1:0]   written, seg_origin;
    logic                    speaking;
    logic [DurWidth-1:0]     quiet_run;
    logic [SegWidth-1:0]     seg_len;
    logic [42:0]             energy_acc;
    logic [12:0]             chunk_len;

    vad_event_t              due[$];
    int                      errors;

    function new();
      mode       = mode_e'(ModeReset);
      thr_sq     = ThrReset;
      preroll    = PrerollReset;
      hold       = HoldReset;
      max_seg    = MaxSegReset;
      overlap    = OverlapReset;
      ring       = RingReset;
      written    = '0;
      seg_origin = '0;
      speaking   = 1'b0;
      quiet_run  = '0;
      seg_len    = '0;
      energy_acc = '0;
      chunk_len  = '0;
      errors     = 0;
    endfunction

    function longint unsigned sat_add(longint unsigned a, longint unsigned b,
                                      longint unsigned lim);
      longint unsigned s;
      s = a + b;
      return (s > lim) ? lim : s;
    endfunction

    function longint unsigned sub_floor(longint unsigned a, longint unsigned b);
      return (a > b) ? a - b : 0;
    endfunction

    // Attach the segment from the current origin to the write count, if not empty.
    function vad_event_t with_segment(vad_event_t ev);
      if (written > seg_origin) begin
        ev.seg_valid = 1'b1;
        ev.seg_start = seg_origin;
        ev.seg_end   = written;
      end
      return ev;
    endfunction

    function void write_reg(logic [CfgIdxWidth-1:0] idx, logic [CfgDataWidth-1:0] data);
      case (idx)
        CfgMode:    mode    = mode_e'(data[0]);
        CfgThrSq:   thr_sq  = data[ThrWidth-1:0];
        CfgPreroll: preroll = data[PrerollWidth-1:0];
        CfgHold:    hold    = data[DurWidth-1:0];
        CfgMaxSeg:  max_seg = data[DurWidth-1:0];
        CfgOverlap: overlap = data[DurWidth-1:0];
        CfgRing:    ring    = data[DurWidth-1:0];
        default: ;
      endcase
    endfunction

    // Note an accepted input transfer and queue the event it causes, if any.
    function void take_item(logic op, logic signed [SampleWidth-1:0] smp, logic last);
      vad_event_t      ev;
      longint          v;
      longint unsigned len, loud_ref, lo_pre, lo_ring;
      ev = '0;
      if (op == OpFlush) begin
        ev.offset  = 1'b1;
        ev         = with_segment(ev);
        seg_origin = written;
        speaking   = 1'b0;
        quiet_run  = '0;
        seg_len    = '0;
        energy_acc = '0;
        chunk_len  = '0;
      end else begin
        v = smp;
        if (written != CountMax) written = written + 1'b1;
        energy_acc = energy_acc + 43'(v * v);
        chunk_len  = chunk_len + 1'b1;
        if (!last && chunk_len < MaxChunk) return;
        len      = chunk_len;
        loud_ref = thr_sq * len;
        if (mode == ModeEnergy) begin
          if (!speaking) begin
            // Energy equal to the threshold does not start speech.
            if (energy_acc > loud_ref) begin
              lo_pre     = sub_floor(written, len + preroll);
              lo_ring    = sub_floor(written, ring);
              speaking   = 1'b1;
              ev.onset   = 1'b1;
              seg_origin = (lo_pre > lo_ring) ? lo_pre : lo_ring;
              quiet_run  = '0;
              seg_len    = (len > SegMax) ? SegMax : len;
            end
          end else begin
            seg_len = sat_add(seg_len, len, SegMax);
            if (energy_acc < loud_ref) begin
              quiet_run = sat_add(quiet_run, len, DurMax);
              if (quiet_run >= hold) begin
                speaking   = 1'b0;
                ev.offset  = 1'b1;
                ev         = with_segment(ev);
                seg_origin = written;
                quiet_run  = '0;
                seg_len    = '0;
              end
            end else begin
              // Loud chunk in speech: a long segment is cut and speech goes on.
              quiet_run = '0;
              if (seg_len >= max_seg) begin
                ev         = with_segment(ev);
                seg_origin = written;
                seg_len    = '0;
              end
            end
          end
        end else begin
          seg_len = sat_add(seg_len, len, SegMax);
          if (seg_len >= max_seg) begin
            ev         = with_segment(ev);
            seg_origin = sub_floor(written, overlap);
            seg_len    = overlap;
          end
        end
        energy_acc = '0;
        chunk_len  = '0;
      end
      ev.active = speaking;
      due.push_back(ev);
    endfunction

    function void check_field(string name, logic [IndexWidth-1:0] want,
                              logic [IndexWidth-1:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compare a result transfer with the oldest event due.
    function void match_result(logic act, logic on, logic off, logic sv,
                               logic [IndexWidth-1:0] st, logic [IndexWidth-1:0] en);
      vad_event_t want;
      if (due.size() == 0) begin
        $display("%0t: result with nothing due, expected none, actual %0b %0b %0b %0b %0d %0d",
                 $time, act, on, off, sv, st, en);
        errors++;
        return;
      end
      want = due.pop_front();
      check_field("speech_active", want.active, act);
      check_field("vad_onset", want.onset, on);
      check_field("vad_offset", want.offset, off);
      check_field("segment_valid", want.seg_valid, sv);
      check_field("segment_start", want.seg_start, st);
      check_field("segment_end", want.seg_end, en);
    endfunction

    function int pending();
      return due.size();
    endfunction

    function void close();
      if (due.size() != 0) begin
        $display("%0t: %0d results expected, actual none", $time, due.size());
        errors += due.size();
      end
    endfunction
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [CfgIdxWidth-1:0]        cfg_index_i = '0;
  logic [CfgDataWidth-1:0]       cfg_data_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic                          op_i = 1'b0;
  logic signed [SampleWidth-1:0] sample_i = '0;
  logic                          last_in_chunk_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic                          speech_active_o;
  logic                          vad_onset_o;
  logic                          vad_offset_o;
  logic                          segment_valid_o;
  logic [IndexWidth-1:0]         segment_start_o;
  logic [IndexWidth-1:0]         segment_end_o;

  segment_tracker trk = new();

  int  sent = 0;
  int  lvl = 1024;
  int  stuck_cycles = 0;
  bit  gap_on = 1'b1;
  bit  stall_on = 1'b1;
  bit  hold_req = 1'b0;
  bit  talking = 1'b0;

  logic [CfgIdxWidth-1:0]  set_idx[$];
  logic [CfgDataWidth-1:0] set_val[$];

  energy_vad_segmenter uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .sample_i        (sample_i),
    .last_in_chunk_i (last_in_chunk_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .speech_active_o (speech_active_o),
    .vad_onset_o     (vad_onset_o),
    .vad_offset_o    (vad_offset_o),
    .segment_valid_o (segment_valid_o),
    .segment_start_o (segment_start_o),
    .segment_end_o   (segment_end_o)
  );

  always #4 clk_i = ~clk_i;

  // Observe every transfer on the three channels.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) trk.write_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_o) trk.take_item(op_i, sample_i, last_in_chunk_i);
      if (out_valid_o && out_ready_i) begin
        trk.match_result(speech_active_o, vad_onset_o, vad_offset_o, segment_valid_o,
                         segment_start_o, segment_end_o);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles == Watchdog) begin
      $display("%0t: no transfer for %0d cycles", $time, Watchdog);
      $display("Mismatches found");
      $finish;
    end
  end

  // Result receiver: random stalls, and a long hold-off when requested.
  initial begin
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldOff) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (stall_on && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  // Offer one input item and return at the edge of its transfer, valid still high.
  task automatic send_item(op_e op, logic signed [SampleWidth-1:0] smp, logic last);
    if (gap_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    op_i            <= op;
    sample_i        <= smp;
    last_in_chunk_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
  endtask

  // Stop offering, wait for every due result, then let the pipeline empty.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (trk.pending() != 0);
    repeat (Settle) @(posedge clk_i);
  endtask

  task automatic queue_reg(logic [CfgIdxWidth-1:0] idx, longint unsigned val);
    set_idx.push_back(idx);
    set_val.push_back(val[CfgDataWidth-1:0]);
  endtask

  task automatic apply_settings();
    while (set_idx.size() != 0) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= set_idx.pop_front();
      cfg_data_i  <= set_val.pop_front();
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic signed [SampleWidth-1:0] pick_sample(int cls);
    int m, v;
    case (cls)
      ClsQuiet: begin
        m = lvl / 2;
        v = int'($urandom_range(0, 2 * m)) - m;
      end
      ClsLoud: begin
        if ($urandom_range(0, 1)) begin
          v = $urandom;
        end else begin
          m = (lvl >= 32767) ? 32767 : lvl + 1;
          v = int'($urandom_range(m, 32767));
          if ($urandom_range(0, 1)) v = -v;
        end
      end
      ClsEqual: v = ($urandom_range(0, 1) || lvl == 32768) ? -lvl : lvl;
      default:  v = $urandom;
    endcase
    return 16'(v);
  endfunction

  // One chunk; a broken chunk is cut short by a flush half-way.
  task automatic send_chunk(int len, int cls, bit broken);
    for (int i = 0; i < len; i++) begin
      if (broken && i == len / 2) begin
        send_item(OpFlush, 16'($urandom), 1'($urandom));
        return;
      end
      send_item(OpSample, pick_sample(cls), i == len - 1);
    end
  endtask

  task automatic run_traffic(int n);
    int first, r, len, cls;
    first = sent;
    while (sent - first < n) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send_item(OpFlush, 16'($urandom), 1'($urandom));
      end else begin
        if ($urandom_range(0, 4) == 0) talking = !talking;
        r = $urandom_range(0, 99);
        len = (r < 75) ? $urandom_range(1, 6) :
              (r < 97) ? $urandom_range(7, 40) : $urandom_range(41, 300);
        r = $urandom_range(0, 99);
        if (talking) cls = (r < 70) ? ClsLoud : (r < 85) ? ClsEqual : ClsNoise;
        else         cls = (r < 80) ? ClsQuiet : (r < 90) ? ClsEqual : ClsNoise;
        send_chunk(len, cls, $urandom_range(0, 19) == 0);
      end
    end
  endtask

  // Choose the register values of one phase; the first three are the extremes.
  task automatic plan_setting(int p);
    mode_e           md;
    longint unsigned thr, k, pre, hld, mseg, ovl, rng;
    int              r;
    case (p)
      0: begin
        md = ModeEnergy; thr = 0; lvl = 0; pre = 0; hld = 0; mseg = 1; ovl = 0; rng = 0;
      end
      1: begin
        md = ModeFixed; thr = 64'h7FFF_FFFF; lvl = 32768; pre = 16'hFFFF;
        hld = DurMax; mseg = DurMax; ovl = DurMax; rng = DurMax;
      end
      2: begin
        md = ModeEnergy; thr = 64'h4000_0000; lvl = 32768; pre = 16'hFFFF;
        hld = DurMax; mseg = DurMax; ovl = DurMax; rng = DurMax;
      end
      default: begin
        md = ($urandom_range(0, 2) == 0) ? ModeFixed : ModeEnergy;
        r = $urandom_range(0, 9);
        if (r < 7) begin
          k = $urandom_range(0, 4000);
          thr = k * k;
          lvl = int'(k);
        end else if (r == 7) begin
          thr = $urandom & 32'h7FFF_FFFF;
          lvl = 1000;
        end else if (r == 8) begin
          thr = 64'h4000_0000;
          lvl = 32768;
        end else begin
          thr = 0;
          lvl = 0;
        end
        r = $urandom_range(0, 9);
        pre = (r == 0) ? 0 : (r == 1) ? 16'hFFFF : (r == 2) ? ($urandom & 16'hFFFF) :
              $urandom_range(1, 80);
        r = $urandom_range(0, 9);
        hld = (r == 0) ? DurMax : (r == 1) ? 0 : $urandom_range(1, 60);
        r = $urandom_range(0, 9);
        mseg = (r == 0) ? DurMax : (r == 1) ? 1 : $urandom_range(4, 160);
        r = $urandom_range(0, 9);
        ovl = (r == 0) ? DurMax : $urandom_range(0, (mseg > 200) ? 200 : int'(mseg));
        r = $urandom_range(0, 9);
        rng = (r == 0) ? 0 : (r == 1) ? DurMax : (r == 2) ? ($urandom & 24'hFF_FFFF) :
              $urandom_range(1, 300);
      end
    endcase
    queue_reg(CfgMode, md);
    queue_reg(CfgThrSq, thr);
    queue_reg(CfgPreroll, pre);
    queue_reg(CfgHold, hld);
    queue_reg(CfgMaxSeg, mseg);
    queue_reg(CfgOverlap, ovl);
    queue_reg(CfgRing, rng);
    // An index with no register behind it must change nothing.
    if (p == 5) queue_reg(CfgUnused, $urandom);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under the reset settings. A loud first chunk starts speech
    // with a start that would fall below zero.
    send_item(OpSample, 16'sh7FFF, 1'b0);
    send_item(OpSample, -16'sd32768, 1'b1);
    // Energy exactly at the threshold keeps speech going.
    send_item(OpSample, 16'sd1024, 1'b1);
    send_item(OpSample, -16'sd1024, 1'b1);
    send_item(OpSample, 16'sd0, 1'b1);
    // Flush with a pending segment, then a flush with nothing left.
    send_item(OpFlush, 16'sh5A5A, 1'b1);
    send_item(OpFlush, 16'sd0, 1'b0);
    // At the threshold out of speech: no onset.
    send_item(OpSample, 16'sd1024, 1'b1);
    // A partial chunk dropped by a flush.
    send_item(OpSample, -16'sd1, 1'b0);
    send_item(OpFlush, -16'sd1, 1'b0);
    send_item(OpSample, 16'sh7FFF, 1'b0);
    send_item(OpSample, 16'sh7FFF, 1'b1);
    send_item(OpSample, 16'sd1, 1'b1);
    send_item(OpFlush, 16'sh7FFF, 1'b1);

    // Random phases, each under a fresh setting written while idle.
    for (int p = 0; p < Phases; p++) begin
      wait_idle();
      plan_setting(p);
      apply_settings();
      gap_on   = (p != Phases - 1) && ($urandom_range(0, 3) != 0);
      stall_on = (p != Phases - 1) && ($urandom_range(0, 3) != 0);
      if (p == 4) hold_req = 1'b1;
      run_traffic(PhaseItems);
      // A chunk with no mark is cut at the largest chunk size.
      if (p == 3) send_chunk(MaxChunk + 5, ClsNoise, 1'b0);
    end

    wait_idle();
    trk.close();
    if (trk.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
